FILE: rtl/assert_macros.svh
// assertion macros shared by the circular deque rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CDQ_ASSERT(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("cdq assertion failed");

// antecedent in one cycle implies consequent in the next cycle
`define CDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdq assertion failed");

`endif

FILE: rtl/cdq_pkg.sv
// shared types and constants for the circular deque
// no dependencies; imported by cdq_ctrl and circular_deque_unit
package cdq_pkg;

    localparam int          DEFAULT_DEPTH = 128;
    localparam int          CAP_W         = 8;
    localparam int          VALUE_W       = 32;
    localparam int          POS_W         = 8;
    localparam logic [7:0]  CAP_RESET     = 8'd128;
    localparam logic [7:0]  POS_NONE      = 8'hFF;

    // operation carried with each input word
    typedef enum logic [1:0] {
        MODE_PUSH_REAR  = 2'd0,
        MODE_POP_FRONT  = 2'd1,
        MODE_PUSH_FRONT = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    // outcome reported with each result word
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-operation result info handed from the pointer control
    typedef struct packed {
        t_status            status;
        logic               pop_ok;
        logic [POS_W-1:0]   front_pos;
        logic [POS_W-1:0]   rear_pos;
    } t_result_info;

endpackage

FILE: rtl/cdq_ctrl.sv
// head/tail pointer control and capacity register of the circular deque
// depends on cdq_pkg and assert_macros.svh
module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_cap,
    input  logic                        i_op_en,
    input  cdq_pkg::t_mode              i_mode,
    output logic                        o_wr_en,
    output logic [IDX_W-1:0]            o_wr_addr,
    output logic [IDX_W-1:0]            o_rd_addr,
    output cdq_pkg::t_result_info       o_info
);
    import cdq_pkg::*;

    `include "assert_macros.svh"

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic             r_empty, n_empty;
    logic [IDX_W-1:0] r_last;

    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic             full;
    logic             push_op;
    logic             wr_en;
    t_status          status;
    logic             pop_ok;
    logic [31:0]      head_ext, tail_ext;

    // last usable index for a capacity value, clamped to 1..DEPTH entries
    function automatic logic [IDX_W-1:0] last_of(input logic [CAP_W-1:0] cap);
        logic [31:0] c;
        begin
            c = 32'(cap);
            if (c == 32'd0) begin
                return '0;
            end
            if (c > 32'(DEPTH)) begin
                return IDX_W'(DEPTH - 1);
            end
            return IDX_W'(c - 32'd1);
        end
    endfunction

    // wrapping neighbors of both pointers
    assign head_inc = (r_head == r_last) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? r_last : r_head - 1'b1;
    assign tail_inc = (r_tail == r_last) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? r_last : r_tail - 1'b1;
    assign full     = !r_empty && (tail_inc == r_head);
    assign push_op  = (i_mode == MODE_PUSH_REAR) || (i_mode == MODE_PUSH_FRONT);

    // next pointer state and outcome of the requested operation
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        wr_en     = 1'b0;
        o_wr_addr = '0;
        status    = ST_DONE;
        pop_ok    = 1'b0;
        case (i_mode)
            MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
                if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                end else if (full) begin
                    status = ST_FULL;
                end else if (i_mode == MODE_PUSH_REAR) begin
                    n_tail    = tail_inc;
                    wr_en     = 1'b1;
                    o_wr_addr = tail_inc;
                end else begin
                    n_head    = head_dec;
                    wr_en     = 1'b1;
                    o_wr_addr = head_dec;
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
                if (r_empty) begin
                    status = ST_EMPTY;
                end else begin
                    pop_ok = 1'b1;
                    if (r_head == r_tail) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else if (i_mode == MODE_POP_FRONT) begin
                        n_head = head_inc;
                    end else begin
                        n_tail = tail_dec;
                    end
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    // pops read the end they remove from
    assign o_rd_addr = (i_mode == MODE_POP_REAR) ? r_tail : r_head;
    assign o_wr_en   = i_op_en && wr_en;

    // positions after the operation, low bits only
    assign head_ext         = 32'(n_head);
    assign tail_ext         = 32'(n_tail);
    assign o_info.status    = status;
    assign o_info.pop_ok    = pop_ok;
    assign o_info.front_pos = n_empty ? POS_NONE : head_ext[POS_W-1:0];
    assign o_info.rear_pos  = n_empty ? POS_NONE : tail_ext[POS_W-1:0];

    // pointer state; a capacity write empties the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_last  <= last_of(CAP_RESET);
        end else if (i_cfg_we) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_last  <= last_of(i_cfg_cap);
        end else if (i_op_en) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    // pointers stay within the configured ring
    `CDQ_ASSERT(a_ptr_in_ring, i_clk, i_rst_n, (r_head <= r_last) && (r_tail <= r_last))
    // an empty queue always sits at the origin
    `CDQ_ASSERT(a_empty_at_origin, i_clk, i_rst_n,
        !r_empty || ((r_head == '0) && (r_tail == '0)))
    // a dropped push leaves the pointers alone
    `CDQ_ASSERT_NEXT(a_full_push_holds, i_clk, i_rst_n,
        i_op_en && !i_cfg_we && push_op && full,
        $stable(r_head) && $stable(r_tail) && !r_empty)

endmodule

FILE: rtl/circular_deque_unit.sv
// top level of the circular deque: stream ports, entry memory, result register
// depends on cdq_pkg, cdq_ctrl and assert_macros.svh

// Double-ended queue of signed 32-bit entries in a circular store of DEPTH
// entries, of which the first "capacity" (the configuration register, 0 acting
// as 1 and values above DEPTH as DEPTH) are used. Each input word carries an
// operation in tuser (push rear, pop front, push front, pop rear) and the value
// to push in tdata. Every input word gives exactly one result word in the next
// cycle: popped value (0 unless a pop succeeded), status (done, full so the
// push was dropped, empty so the pop gave nothing) and the front and rear
// positions after the operation, 0xFF when empty. One operation per cycle is
// sustained while results are taken: the pointer update is a single compare
// and increment, and the entry memory does one write (push) or one registered
// read (pop) per cycle. The input is stalled during reset and while a result
// is held by the output side; capacity writes are taken only outside reset.
// No clearing pass is needed after reset. Writing the capacity empties the queue.
module circular_deque_unit #(
    parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write: capacity
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]       i_cfg_data,
    // input words
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [31:0]                     i_s_axis_tdata,  // [31:0] push_value
    input  logic [1:0]                      i_s_axis_tuser,  // [1:0] mode
    // result words
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [47:0]                     o_m_axis_tdata,  // [31:0] pop_value,
                                                             // [39:32] front_pos,
                                                             // [47:40] rear_pos
    output logic [1:0]                      o_m_axis_tuser   // [1:0] status
);
    import cdq_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(DEPTH);

    logic               s_accept;
    logic               m_accept;
    logic               cfg_we;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [IDX_W-1:0]   mem_rd_addr;
    t_result_info       info;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;
    t_result_info       r_info;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] pop_value;

    // handshakes, nothing taken while in reset
    assign o_cfg_ready     = i_rst_n;
    assign cfg_we          = i_cfg_valid && o_cfg_ready;
    assign o_s_axis_tready = i_rst_n && (!r_out_valid || i_m_axis_tready);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_accept        = r_out_valid && i_m_axis_tready;

    // pointer control
    cdq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_cap (i_cfg_data),
        .i_op_en   (s_accept),
        .i_mode    (t_mode'(i_s_axis_tuser)),
        .o_wr_en   (mem_we),
        .o_wr_addr (mem_wr_addr),
        .o_rd_addr (mem_rd_addr),
        .o_info    (info)
    );

    // entry memory write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= i_s_axis_tdata;
        end
    end

    // entry memory read port, registered with the result
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_rd_data <= r_mem[mem_rd_addr];
            r_info    <= info;
        end
    end

    // result word valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (s_accept) begin
            n_out_valid = 1'b1;
        end else if (m_accept) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result word packing
    assign pop_value       = r_info.pop_ok ? r_rd_data : '0;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_info.rear_pos, r_info.front_pos, pop_value};
    assign o_m_axis_tuser  = r_info.status;

    // memory is written only for an accepted word
    `CDQ_ASSERT(a_write_on_accept, i_clk, i_rst_n, !mem_we || s_accept)
    // every accepted word shows up as a result in the next cycle
    `CDQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, s_accept, o_m_axis_tvalid)
    // a failed operation reports a zero value
    `CDQ_ASSERT(a_fail_zero_value, i_clk, i_rst_n,
        !r_out_valid || (r_info.status == ST_DONE) || (o_m_axis_tdata[31:0] == '0))

endmodule
